### design/csi_block_float_unpack_macros.svh
// Assertion helpers for the tone unpacker
`ifndef CSI_BLOCK_FLOAT_UNPACK_MACROS_SVH
`define CSI_BLOCK_FLOAT_UNPACK_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CSIBFU_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define CSIBFU_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### design/csibfu_pkg.sv
package csibfu_pkg;

  typedef enum logic [1:0] {
    CFG_OUT_BITS      = 2'd0,
    CFG_AUTOSCALE_ON  = 2'd1,
    CFG_MANTISSA_BITS = 2'd2,
    CFG_EXPONENT_BITS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0] out_bits;
    logic       autoscale_on;
    logic [3:0] mantissa_bits;
    logic [3:0] exponent_bits;
  } cfg_t;

  localparam int CfgDataW = 5;
  localparam logic [4:0] OutBitsRst = 5'd10;
  localparam logic       AutoscaleRst = 1'b1;
  localparam logic [3:0] MantBitsRst = 4'd9;
  localparam logic [3:0] ExpBitsRst = 4'd5;
  localparam logic signed [8:0] MaxBitRst = -9'sd16;
  localparam int ExpMaxW = 8;

  function automatic logic [3:0] exp_width(input logic [3:0] eb);
    return (eb > 4'd8) ? 4'd8 : eb;
  endfunction

  function automatic logic signed [8:0] half_range(input logic [3:0] n);
    logic [8:0] h;
    h = (n == 4'd0) ? 9'd0 : (9'd1 << (n - 4'd1));
    return $signed(h);
  endfunction

  function automatic logic [14:0] mag_mask(input logic [3:0] m);
    logic [15:0] t;
    t = (m == 4'd0) ? 16'd0 : ((16'd1 << (m - 4'd1)) - 16'd1);
    return t[14:0];
  endfunction

  function automatic logic [14:0] mag_field(input logic [31:0] w, input logic [4:0] sh,
                                            input logic [3:0] m);
    logic [31:0] t;
    t = w >> sh;
    return t[14:0] & mag_mask(m);
  endfunction

  // two's complement exponent in the low n bits
  function automatic logic signed [8:0] decode_exp(input logic [31:0] w,
                                                   input logic [3:0] n);
    logic [8:0] msk;
    logic [7:0] f;
    logic [9:0] r;
    msk = (9'd1 << n) - 9'd1;
    f = w[ExpMaxW-1:0] & msk[7:0];
    r = {2'b00, f};
    if (n != 4'd0 && f[3'(n - 4'd1)]) begin
      r = {2'b00, f} - (10'd1 << n);
    end
    return $signed(r[8:0]);
  endfunction

  // sign bit sitting at position s-1; nothing beyond bit 31
  function automatic logic sign_at(input logic [31:0] w, input logic [5:0] s);
    logic [5:0] p;
    p = s - 6'd1;
    return (s == 6'd0 || s > 6'd32) ? 1'b0 : w[p[4:0]];
  endfunction

  function automatic logic [3:0] floor_log2(input logic [14:0] x);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (x[i]) r = 4'(i);
    end
    return r;
  endfunction

  function automatic logic [31:0] scale_mag(input logic [14:0] mag, input logic neg,
                                            input logic signed [10:0] e,
                                            input logic [3:0] m);
    logic [31:0] v;
    logic signed [10:0] ne;
    ne = -e;
    if (e < -$signed({7'd0, m})) begin
      v = 32'd0;
    end else if (e < 11'sd0) begin
      v = {17'd0, mag} >> ne[3:0];
    end else if (e >= 11'sd32) begin
      v = 32'd0;
    end else begin
      v = {17'd0, mag} << e[4:0];
    end
    return neg ? (32'd0 - v) : v;
  endfunction

endpackage

### design/csibfu_if.sv
interface csibfu_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_word;
  logic        last_tone;

  modport source (output valid, output packed_word, output last_tone, input ready);
  modport sink (input valid, input packed_word, input last_tone, output ready);
endinterface

interface csibfu_tone_if;
  logic               valid;
  logic               ready;
  logic [5:0]         tone_index;
  logic signed [31:0] value_i;
  logic signed [31:0] value_q;
  logic               last_out;

  modport source (output valid, output tone_index, output value_i, output value_q,
                  output last_out, input ready);
  modport sink (input valid, input tone_index, input value_i, input value_q,
                input last_out, output ready);
endinterface

### design/csibfu_queue.sv
module csibfu_queue #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output logic [DW-1:0] head_data_o
);
  logic [DW-1:0] ent_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q, cnt_d;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_data_o  = ent_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    if (!push_i && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wptr_q] <= push_data_i;
  end
endmodule

### design/csibfu_front.sv
module csibfu_front #(
  parameter int MAX_TONES = 64,
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csibfu_pkg::cfg_t      cfg_i,
  csibfu_word_if.sink           word_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output logic                  push_bank_o,
  output logic [CW-1:0]         push_count_o,
  output logic signed [8:0]     push_max_o,
  output logic                  mem_we_o,
  output logic [AW:0]           mem_waddr_o,
  output logic [31:0]           mem_wdata_o
);
  import csibfu_pkg::*;

  localparam logic [CW-1:0] FullCnt = CW'(MAX_TONES);

  logic [CW-1:0]      count_q, count_d, count_inc;
  logic signed [8:0]  max_q, max_d, base, new_max;
  logic               bank_q, bank_d;
  logic               beat, close;
  logic [3:0]         n, m, lg;
  logic [14:0]        mi, mq, x;
  logic signed [9:0]  e_tone;

  assign word_i.ready = !q_full_i;
  assign beat = word_i.valid && word_i.ready;

  always_comb begin
    n  = exp_width(cfg_i.exponent_bits);
    m  = cfg_i.mantissa_bits;
    mi = mag_field(word_i.packed_word, 5'({1'b0, n} + {1'b0, m}), m);
    mq = mag_field(word_i.packed_word, {1'b0, n}, m);
    x  = mi | mq;
    lg = floor_log2(x);
    e_tone = 10'(decode_exp(word_i.packed_word, n)) + $signed({6'd0, lg});
    base = (count_q == '0) ? -half_range(n) : max_q;
    new_max = base;
    if (cfg_i.autoscale_on && x != 15'd0 && e_tone > 10'(base)) begin
      new_max = e_tone[8:0];
    end
  end

  assign count_inc = CW'(count_q + 1'b1);
  assign close = word_i.last_tone || (count_inc == FullCnt);

  always_comb begin
    count_d = count_q;
    max_d   = max_q;
    bank_d  = bank_q;
    if (beat) begin
      max_d = new_max;
      if (close) begin
        count_d = '0;
        bank_d  = ~bank_q;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      max_q   <= MaxBitRst;
      bank_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      max_q   <= max_d;
      bank_q  <= bank_d;
    end
  end

  assign push_o       = beat && close;
  assign push_bank_o  = bank_q;
  assign push_count_o = count_inc;
  assign push_max_o   = new_max;

  assign mem_we_o    = beat;
  assign mem_waddr_o = {bank_q, count_q[AW-1:0]};
  assign mem_wdata_o = word_i.packed_word;
endmodule

### design/csibfu_back.sv
module csibfu_back #(
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csibfu_pkg::cfg_t      cfg_i,
  input  logic                  mem_we_i,
  input  logic [AW:0]           mem_waddr_i,
  input  logic [31:0]           mem_wdata_i,
  input  logic                  hd_valid_i,
  input  logic                  hd_bank_i,
  input  logic [CW-1:0]         hd_count_i,
  input  logic signed [8:0]     hd_max_i,
  output logic                  pop_o,
  csibfu_tone_if.source         tone_o
);
  import csibfu_pkg::*;

  localparam int Depth = 2 ** (AW + 1);

  logic [31:0]        mem [Depth];
  logic [31:0]        rdata_q;
  logic [AW-1:0]      tag_idx_q;
  logic               tag_last_q;
  logic [CW-1:0]      rd_idx_q, rd_idx_d;
  logic               rd_pend_q, rd_pend_d;
  logic               out_valid_q, out_valid_d;
  logic               issue, load_out;
  logic [3:0]         n, m;
  logic signed [9:0]  shft;
  logic signed [10:0] e_tone;
  logic [14:0]        mi, mq;
  logic               si, sq;
  logic [5:0]         tone_index_q;
  logic [31:0]        value_i_q, value_q_q;
  logic               last_out_q;

  assign load_out = rd_pend_q && (!out_valid_q || tone_o.ready);
  assign issue    = hd_valid_i && (rd_idx_q < hd_count_i) && (!rd_pend_q || load_out);
  assign pop_o    = load_out && tag_last_q;

  always_comb begin
    rd_idx_d = rd_idx_q;
    if (issue) rd_idx_d = CW'(rd_idx_q + 1'b1);
    if (pop_o) rd_idx_d = '0;
    rd_pend_d   = issue || (rd_pend_q && !load_out);
    out_valid_d = load_out || (out_valid_q && !tone_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_idx_q    <= rd_idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we_i) mem[mem_waddr_i] <= mem_wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q    <= mem[{hd_bank_i, rd_idx_q[AW-1:0]}];
      tag_idx_q  <= rd_idx_q[AW-1:0];
      tag_last_q <= (CW'(rd_idx_q + 1'b1) == hd_count_i);
    end
  end

  always_comb begin
    n      = exp_width(cfg_i.exponent_bits);
    m      = cfg_i.mantissa_bits;
    shft   = $signed({5'd0, cfg_i.out_bits}) - 10'(hd_max_i);
    e_tone = 11'(decode_exp(rdata_q, n)) + 11'(shft);
    mi     = mag_field(rdata_q, 5'({1'b0, n} + {1'b0, m}), m);
    mq     = mag_field(rdata_q, {1'b0, n}, m);
    si     = sign_at(rdata_q, {2'b00, n} + {1'b0, m, 1'b0});
    sq     = sign_at(rdata_q, {2'b00, n} + {2'b00, m});
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      tone_index_q <= 6'(tag_idx_q);
      value_i_q    <= scale_mag(mi, si, e_tone, m);
      value_q_q    <= scale_mag(mq, sq, e_tone, m);
      last_out_q   <= tag_last_q;
    end
  end

  assign tone_o.valid      = out_valid_q;
  assign tone_o.tone_index = tone_index_q;
  assign tone_o.value_i    = $signed(value_i_q);
  assign tone_o.value_q    = $signed(value_q_q);
  assign tone_o.last_out   = last_out_q;
endmodule

### design/csi_block_float_unpack.sv
// Block floating point I/Q unpacker.
// word_i (valid/ready) takes one packed tone word per beat: sign/magnitude I and
// Q mantissas above a two's complement exponent; last_tone closes the set, as
// does the beat that fills MAX_TONES entries. tone_o (valid/ready) then gives
// one beat per stored tone in load order, last_out on the final one.
// cfg_we_i/cfg_idx_i/cfg_data_i write out_bits, autoscale_on, mantissa_bits and
// exponent_bits; write them only while no set is in flight.
// Words land in one half of a two-bank word memory at one per cycle, so input
// throughput is one word per cycle while the set queue has room. A closed set
// is handed to the drain side through a two-entry set queue; the drain reads the
// memory at one tone per cycle while tone_o does not stall, and pauses between
// sets; loading of the next set overlaps draining of the last.
// The set queue, read register and output register lie before the first result.
// word_i.ready drops while both banks hold sets not yet fully drained.
// A stall on tone_o holds the output register and then the one pending memory
// read; the front keeps loading until both banks are taken.
// Reset empties the set queue, clears the tone count and loads the registers
// with out_bits 10, autoscale on, 9 mantissa bits and 5 exponent bits.
module csi_block_float_unpack #(
  parameter int MAX_TONES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  csibfu_pkg::cfg_idx_e                cfg_idx_i,
  input  logic [csibfu_pkg::CfgDataW-1:0]     cfg_data_i,
  csibfu_word_if.sink                         word_i,
  csibfu_tone_if.source                       tone_o
);
  import csibfu_pkg::*;

  localparam int AW = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int CW = $clog2(MAX_TONES + 1);
  localparam int QW = 1 + CW + 9;

  cfg_t                cfg_q;
  logic                q_full, push, push_bank, pop, hd_valid;
  logic [CW-1:0]       push_count;
  logic signed [8:0]   push_max;
  logic [QW-1:0]       hd_data;
  logic                mem_we;
  logic [AW:0]         mem_waddr;
  logic [31:0]         mem_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_bits      <= OutBitsRst;
      cfg_q.autoscale_on  <= AutoscaleRst;
      cfg_q.mantissa_bits <= MantBitsRst;
      cfg_q.exponent_bits <= ExpBitsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OUT_BITS:      cfg_q.out_bits      <= cfg_data_i[4:0];
        CFG_AUTOSCALE_ON:  cfg_q.autoscale_on  <= cfg_data_i[0];
        CFG_MANTISSA_BITS: cfg_q.mantissa_bits <= cfg_data_i[3:0];
        CFG_EXPONENT_BITS: cfg_q.exponent_bits <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  csibfu_front #(.MAX_TONES(MAX_TONES), .AW(AW), .CW(CW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .word_i       (word_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_bank_o  (push_bank),
    .push_count_o (push_count),
    .push_max_o   (push_max),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata)
  );

  csibfu_queue #(.DW(QW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  ({push_bank, push_count, push_max}),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (hd_valid),
    .head_data_o  (hd_data)
  );

  csibfu_back #(.AW(AW), .CW(CW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mem_we_i    (mem_we),
    .mem_waddr_i (mem_waddr),
    .mem_wdata_i (mem_wdata),
    .hd_valid_i  (hd_valid),
    .hd_bank_i   (hd_data[QW-1]),
    .hd_count_i  (hd_data[QW-2:9]),
    .hd_max_i    ($signed(hd_data[8:0])),
    .pop_o       (pop),
    .tone_o      (tone_o)
  );
endmodule

### design/csibfu_checker.sv
`include "csi_block_float_unpack_macros.svh"

module csibfu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        word_valid_i,
  input logic        word_ready_i,
  input logic        tone_valid_i,
  input logic        tone_ready_i,
  input logic [5:0]  tone_index_i,
  input logic [31:0] value_i_i,
  input logic [31:0] value_q_i,
  input logic        last_out_i
);
  logic        word_beat, tone_beat;
  logic [5:0]  exp_idx_q;
  logic [15:0] pend_q;

  assign word_beat = word_valid_i && word_ready_i;
  assign tone_beat = tone_valid_i && tone_ready_i;

  // expected tone index and words held but not yet emitted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= 6'd0;
      pend_q    <= 16'd0;
    end else begin
      if (tone_beat) exp_idx_q <= last_out_i ? 6'd0 : 6'(tone_index_i + 6'd1);
      pend_q <= pend_q + {15'd0, word_beat} - {15'd0, tone_beat};
    end
  end

  `CSIBFU_ASSERT_NXT(a_tone_hold, tone_valid_i && !tone_ready_i,
    tone_valid_i && $stable(tone_index_i) && $stable(value_i_i) && $stable(value_q_i)
    && $stable(last_out_i), "tone beat changed while stalled")
  `CSIBFU_ASSERT_IMP(a_index_seq, tone_beat, tone_index_i == exp_idx_q,
    "tone index out of sequence")
  `CSIBFU_ASSERT_IMP(a_no_invent, tone_beat, pend_q != 16'd0,
    "tone beat with no word held")
endmodule

bind csi_block_float_unpack csibfu_checker u_csibfu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .word_valid_i (word_i.valid),
  .word_ready_i (word_i.ready),
  .tone_valid_i (tone_o.valid),
  .tone_ready_i (tone_o.ready),
  .tone_index_i (tone_o.tone_index),
  .value_i_i    (tone_o.value_i),
  .value_q_i    (tone_o.value_q),
  .last_out_i   (tone_o.last_out)
);
